// ===== rtl/sobel_et_pkg.sv =====
// Package for the Sobel edge/threshold block: widths, register index codes,
// command codes and reset values. No dependencies.
package sobel_et_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LINE_W     = 2 * PIX_W;   // {upper, middle}
  localparam int unsigned SUM_W      = 10;          // r+g+b
  localparam int unsigned GRAY_PW    = 20;          // sum * reciprocal
  localparam int unsigned GRAD_W     = 11;          // signed gradient
  localparam int unsigned ABS_W      = 10;
  localparam int unsigned SQ_W       = 20;
  localparam int unsigned MAG_W      = 21;
  localparam int unsigned LIM_W      = 23;

  // floor(s/3) == (s*683) >> 11 for s <= 765
  localparam int unsigned GRAY_MUL   = 683;
  localparam int unsigned GRAY_SHIFT = 11;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [THR_W-1:0]    EDGE_THR_RST     = 11'd128;
  localparam logic [LIM_W-1:0]    LIM_SQ_RST       = 23'd16641; // (128+1)^2

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

endpackage

// ===== rtl/sobel_et_if.sv =====
// Handshake channels of the Sobel edge/threshold block: pixel requests,
// results and configuration writes. Depends on sobel_et_pkg.
interface sobel_et_pix_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [sobel_et_pkg::PIX_W-1:0] red_in;
  logic [sobel_et_pkg::PIX_W-1:0] green_in;
  logic [sobel_et_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface sobel_et_res_if;
  logic                           valid;
  logic                           ready;
  logic [sobel_et_pkg::PIX_W-1:0] edge_value;
  logic                           frame_end;

  modport source (output valid, edge_value, frame_end, input ready);
  modport sink   (input valid, edge_value, frame_end, output ready);
endinterface

interface sobel_et_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sobel_et_pkg::CFG_IDX_W-1:0]  index;
  logic [sobel_et_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sobel_edge_threshold_top.sv =====
// Sobel edge detector with magnitude threshold, top level.
// Depends on sobel_et_pkg, sobel_et_if.sv and sobel_et_line_mem.
//
// Usage:
//  - pix_i takes one request per cycle while ready is high: command 0 carries an
//    RGB pixel in raster order, command 1 drains one pending result once the
//    whole frame is in. Requests that do nothing (pixel after the frame is
//    complete, drain too early) are still taken and give no result.
//  - res_o gives one result per pixel request from the second line on
//    (one line plus one pixel behind) and one per useful drain; edge_value
//    is 0 for an edge or border pixel, 255 otherwise; frame_end flags the
//    last result of the frame, after which a new frame starts.
//  - cfg_i is always ready; write only while idle. A geometry write restarts
//    the frame, a threshold write applies at once.
//  - Five register stages (stages 1 to 4 and the output register) lie between
//    pix_i and res_o. Throughput: one request per cycle while res_o is not
//    stalled, set by the single read-modify-write of the line store per pixel.
//  - Reset: position counters clear, config registers take their defaults; the line
//    store is not cleared (its old contents only reach border pixels).
//  - A stalled receiver holds the output register; the pipeline stages fill
//    behind it and pix_i.ready drops only when every stage is occupied.
module sobel_edge_threshold_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sobel_et_pix_if.sink   pix_i,
  sobel_et_res_if.source res_o,
  sobel_et_cfg_if.sink   cfg_i
);

  localparam int unsigned PW     = sobel_et_pkg::PIX_W;
  localparam int unsigned WW     = sobel_et_pkg::WIDTH_W;
  localparam int unsigned HW     = sobel_et_pkg::HEIGHT_W;
  localparam int unsigned TW     = sobel_et_pkg::THR_W;
  localparam int unsigned LW     = sobel_et_pkg::LINE_W;
  localparam int unsigned GW     = sobel_et_pkg::GRAD_W;
  localparam int unsigned AW_ABS = sobel_et_pkg::ABS_W;
  localparam int unsigned SQW    = sobel_et_pkg::SQ_W;
  localparam int unsigned MW     = sobel_et_pkg::MAG_W;
  localparam int unsigned LIMW   = sobel_et_pkg::LIM_W;
  localparam int unsigned SW     = sobel_et_pkg::SUM_W;
  localparam int unsigned GPW    = sobel_et_pkg::GRAY_PW;
  localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WMAX   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam logic [WW-1:0] W_CLAMP = WW'(WMAX);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic            cfg_wr, geom_wr;
  logic [WW-1:0]   frame_width_q;
  logic [HW-1:0]   frame_height_q;
  logic [TW-1:0]   edge_thr_q;
  logic [LIMW-1:0] lim_sq_q, lim_sq_d;
  logic [TW:0]     lim;
  logic [2*TW+1:0] lim_prod;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr  = cfg_i.valid && cfg_i.ready;
  assign geom_wr = cfg_wr &&
                   ((cfg_i.index == sobel_et_pkg::CFG_FRAME_WIDTH) ||
                    (cfg_i.index == sobel_et_pkg::CFG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sobel_et_pkg::FRAME_WIDTH_RST;
      frame_height_q <= sobel_et_pkg::FRAME_HEIGHT_RST;
      edge_thr_q     <= sobel_et_pkg::EDGE_THR_RST;
    end else if (cfg_wr) begin
      case (sobel_et_pkg::cfg_idx_e'(cfg_i.index))
        sobel_et_pkg::CFG_FRAME_WIDTH:    frame_width_q  <= cfg_i.data[WW-1:0];
        sobel_et_pkg::CFG_FRAME_HEIGHT:   frame_height_q <= cfg_i.data[HW-1:0];
        sobel_et_pkg::CFG_EDGE_THRESHOLD: edge_thr_q     <= cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // squared limit, registered for the compare in stage 4
  assign lim      = {1'b0, edge_thr_q} + (TW+1)'(1);
  assign lim_prod = (2*TW+2)'(lim) * (2*TW+2)'(lim);
  assign lim_sq_d = lim_prod[LIMW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_sq_q <= sobel_et_pkg::LIM_SQ_RST;
    end else begin
      lim_sq_q <= lim_sq_d;
    end
  end

  // effective geometry
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (frame_width_q > W_CLAMP) begin
      w_eff = W_CLAMP;
    end else begin
      w_eff = frame_width_q;
    end
    h_eff = (frame_height_q == '0) ? HW'(1) : frame_height_q;
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage moves when the next one is free
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic out_take, rdy4, rdy3, rdy2, rdy1;
  logic pix_acc;

  assign out_take = !ov_q || res_o.ready;
  assign rdy4     = !v4_q || out_take;
  assign rdy3     = !v3_q || rdy4;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;

  assign pix_i.ready = rdy1;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  // ---------------------------------------------------------------------
  // Stage 0: position tracking, grey conversion, line store read
  // ---------------------------------------------------------------------
  logic [WW-1:0] col_q, out_col_q;
  logic [HW-1:0] row_q, out_row_q;
  logic          all_in, is_drain, pix_ok, drain_ok, have_out, interior;
  logic          emit, out_last, fend;
  logic [SW-1:0]  rgb_sum;
  logic [GPW-1:0] gray_prod;
  logic [PW-1:0]  gray;

  assign all_in   = row_q >= h_eff;
  assign is_drain = pix_i.command == sobel_et_pkg::CMD_DRAIN;
  assign pix_ok   = !is_drain && !all_in;
  assign drain_ok = is_drain && all_in;
  // output index (seen - width - 1) exists
  assign have_out = (row_q >= HW'(2)) || ((row_q == HW'(1)) && (col_q != '0));
  assign interior = (row_q >= HW'(2)) && (col_q >= WW'(2));
  assign emit     = drain_ok || (pix_ok && have_out);
  assign out_last = (out_col_q == w_eff - WW'(1)) && (out_row_q == h_eff - HW'(1));
  assign fend     = emit && out_last;

  assign rgb_sum   = SW'(pix_i.red_in) + SW'(pix_i.green_in) + SW'(pix_i.blue_in);
  assign gray_prod = GPW'(rgb_sum) * GPW'(sobel_et_pkg::GRAY_MUL);
  assign gray      = gray_prod[sobel_et_pkg::GRAY_SHIFT +: PW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (geom_wr) begin
      col_q     <= '0;
      row_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (pix_acc) begin
      if (fend) begin
        col_q     <= '0;
        row_q     <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (pix_ok) begin
          if (col_q == w_eff - WW'(1)) begin
            col_q <= '0;
            row_q <= row_q + HW'(1);
          end else begin
            col_q <= col_q + WW'(1);
          end
        end
        if (emit) begin
          if (out_col_q == w_eff - WW'(1)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HW'(1);
          end else begin
            out_col_q <= out_col_q + WW'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store data back; write-back and window shift on exit
  // ---------------------------------------------------------------------
  logic              s1_pix_q, s1_emit_q, s1_int_q, s1_fend_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PW-1:0]     s1_gray_q;
  logic [LW-1:0]     line_rd;
  logic [PW-1:0]     up_px, mid_px;
  logic              s1_move, mem_wr;

  assign s1_move = v1_q && rdy2;
  assign mem_wr  = s1_move && s1_pix_q;
  assign up_px   = line_rd[LW-1:PW];
  assign mid_px  = line_rd[PW-1:0];

  sobel_et_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (pix_acc && pix_ok),
    .rd_addr_i (ADDR_W'(col_q)),
    .wr_en_i   (mem_wr),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid_px, s1_gray_q}),
    .rd_data_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= pix_acc && (pix_ok || drain_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_pix_q  <= pix_ok;
      s1_emit_q <= emit;
      s1_int_q  <= interior;
      s1_fend_q <= fend;
      s1_addr_q <= ADDR_W'(col_q);
      s1_gray_q <= gray;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: 3x3 window, gradients and their magnitudes
  // ---------------------------------------------------------------------
  logic [PW-1:0] win_q [3][3];
  logic          s2_int_q, s2_fend_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= up_px;
      win_q[1][2] <= mid_px;
      win_q[2][2] <= s1_gray_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_int_q  <= s1_int_q;
      s2_fend_q <= s1_fend_q;
    end
  end

  logic [AW_ABS-1:0]    gx_p, gx_n, gy_p, gy_n, ax, ay;
  logic signed [GW-1:0] gx, gy;

  assign gx_p = AW_ABS'(win_q[0][2]) + AW_ABS'({win_q[1][2], 1'b0}) + AW_ABS'(win_q[2][2]);
  assign gx_n = AW_ABS'(win_q[0][0]) + AW_ABS'({win_q[1][0], 1'b0}) + AW_ABS'(win_q[2][0]);
  assign gy_p = AW_ABS'(win_q[2][0]) + AW_ABS'({win_q[2][1], 1'b0}) + AW_ABS'(win_q[2][2]);
  assign gy_n = AW_ABS'(win_q[0][0]) + AW_ABS'({win_q[0][1], 1'b0}) + AW_ABS'(win_q[0][2]);
  assign gx   = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
  assign gy   = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
  assign ax   = gx[GW-1] ? AW_ABS'(-gx) : AW_ABS'(gx);
  assign ay   = gy[GW-1] ? AW_ABS'(-gy) : AW_ABS'(gy);

  // ---------------------------------------------------------------------
  // Stage 3: squares
  // ---------------------------------------------------------------------
  logic [AW_ABS-1:0] ax_q, ay_q;
  logic              s3_int_q, s3_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      ax_q      <= ax;
      ay_q      <= ay;
      s3_int_q  <= s2_int_q;
      s3_fend_q <= s2_fend_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sum of squares against the squared limit
  // ---------------------------------------------------------------------
  logic [SQW-1:0] sqx_q, sqy_q;
  logic           s4_int_q, s4_fend_q;
  logic [MW-1:0]  mag_sq;
  logic [PW-1:0]  edge_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sqx_q     <= SQW'(ax_q) * SQW'(ax_q);
      sqy_q     <= SQW'(ay_q) * SQW'(ay_q);
      s4_int_q  <= s3_int_q;
      s4_fend_q <= s3_fend_q;
    end
  end

  assign mag_sq   = MW'(sqx_q) + MW'(sqy_q);
  // border pixels and edges are black
  assign edge_val = (s4_int_q && (LIMW'(mag_sq) < lim_sq_q)) ?
                    sobel_et_pkg::PIX_WHITE : sobel_et_pkg::PIX_BLACK;

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [PW-1:0] out_val_q;
  logic          out_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_take) begin
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_val_q  <= edge_val;
      out_fend_q <= s4_fend_q;
    end
  end

  assign res_o.valid      = ov_q;
  assign res_o.edge_value = out_val_q;
  assign res_o.frame_end  = out_fend_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // input column stays inside the line
  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < w_eff)
    else $error("column position beyond frame width");

  // input row never passes the frame end
  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_eff)
    else $error("row position beyond frame height");

  // results never run ahead of the input
  a_out_lags_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= row_q)
    else $error("output position ahead of input position");

  // the last result of a frame is on the bottom border
  a_fend_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> (res_o.edge_value == sobel_et_pkg::PIX_BLACK))
    else $error("frame end flagged on a non-border result");

endmodule

// ===== rtl/sobel_et_line_mem.sv =====
// Line store memory: one write and one registered read port, upper and middle
// lines packed per entry. Same-cycle write to the read address is forwarded.
// Depends on sobel_et_pkg.
module sobel_et_line_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [ADDR_W-1:0]               rd_addr_i,
  input  logic                            wr_en_i,
  input  logic [ADDR_W-1:0]               wr_addr_i,
  input  logic [sobel_et_pkg::LINE_W-1:0] wr_data_i,
  output logic [sobel_et_pkg::LINE_W-1:0] rd_data_o
);

  logic [sobel_et_pkg::LINE_W-1:0] mem_q [DEPTH];
  logic [sobel_et_pkg::LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first on an address clash
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
